### design/dcos_pkg.sv
`timescale 1ns / 1ps

package dcos_pkg;

    // Column storage and field widths
    localparam int MaxRows = 512;
    localparam int RowW    = $clog2(MaxRows);
    localparam int CntW    = RowW + 1;
    localparam int SumYW   = 26;
    localparam int SumYzW  = 41;
    localparam int SumYyW  = 40;
    localparam int PtW     = 48;

    localparam logic signed [15:0] HighMm = 16'sd200;
    localparam logic signed [15:0] TopMm  = 16'sd1700;

    // Configuration register indexes
    localparam logic [1:0] RegSlope  = 2'd0;
    localparam logic [1:0] RegWindow = 2'd1;
    localparam logic [1:0] RegMin    = 2'd2;
    localparam logic [1:0] RegMax    = 2'd3;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_WAIT,
        ST_MUL1,
        ST_MUL2,
        ST_SUB,
        ST_CMP_A,
        ST_CMP_B,
        ST_DECIDE,
        ST_OUT
    } dcos_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_row;    // store accepted row
        logic scan_start;  // set scan index to window
        logic scan_read;   // issue store reads for scan row
        logic mul1;        // multiply stage one
        logic mul2;        // multiply stage two
        logic sub;         // form num and den
        logic cmp_a;       // threshold product halves
        logic cmp_b;       // compare |num| with product
        logic decide;      // offer candidate, advance row
        logic finish;      // load result, clear column
    } dcos_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_empty;  // no rows left in window range
        logic scan_skip;   // current row not slope-tested
    } dcos_stat_t;

endpackage

### design/dcos_ctrl.sv
`timescale 1ns / 1ps

module dcos_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_last_row,
    output logic                m_valid,
    input  logic                m_ready,
    output dcos_pkg::dcos_cmd_t cmd,
    input  dcos_pkg::dcos_stat_t stat
);
    import dcos_pkg::*;

    dcos_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        s_fire;

    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // Hold the next state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:      if (s_fire && s_last_row) state_next = ST_SCAN_RD;
            ST_SCAN_RD:   begin
                if (stat.scan_empty) state_next = ST_OUT;
                else                 state_next = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT: begin
                if (stat.scan_skip) state_next = ST_DECIDE;
                else                state_next = ST_MUL1;
            end
            ST_MUL1:      state_next = ST_MUL2;
            ST_MUL2:      state_next = ST_SUB;
            ST_SUB:       state_next = ST_CMP_A;
            ST_CMP_A:     state_next = ST_CMP_B;
            ST_CMP_B:     state_next = ST_DECIDE;
            ST_DECIDE:    state_next = ST_SCAN_RD;
            ST_OUT:       if (!m_valid_reg || m_ready) state_next = ST_LOAD;
            default:      state_next = ST_LOAD;
        endcase
    end

    // Outputs
    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready        = 1'b1;
                cmd.load_row   = s_fire;
                cmd.scan_start = s_fire && s_last_row;
            end
            ST_SCAN_RD:   cmd.scan_read = !stat.scan_empty;
            ST_SCAN_WAIT: ;
            ST_MUL1:      cmd.mul1 = 1'b1;
            ST_MUL2:      cmd.mul2 = 1'b1;
            ST_SUB:       cmd.sub = 1'b1;
            ST_CMP_A:     cmd.cmp_a = 1'b1;
            ST_CMP_B:     cmd.cmp_b = 1'b1;
            ST_DECIDE:    cmd.decide = 1'b1;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

### design/dcos_dp.sv
`timescale 1ns / 1ps

module dcos_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic signed [15:0]          s_point_x,
    input  logic signed [15:0]          s_point_y,
    input  logic signed [15:0]          s_point_z,
    input  logic                        s_depth_ok,
    input  logic                        cfg_valid,
    input  logic [1:0]                  cfg_index,
    input  logic [15:0]                 cfg_data,
    output logic                        m_found,
    output logic signed [15:0]          m_near_x,
    output logic signed [15:0]          m_near_y,
    output logic signed [15:0]          m_near_z,
    input  dcos_pkg::dcos_cmd_t         cmd,
    output dcos_pkg::dcos_stat_t        stat
);
    import dcos_pkg::*;

    // Configuration registers
    logic [15:0]        thr_reg;
    logic [6:0]         win_reg;
    logic signed [15:0] min_reg, max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= 16'd256;
            win_reg <= 7'd10;
            min_reg <= 16'sd0;
            max_reg <= 16'sd3000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                RegSlope:  thr_reg <= cfg_data;
                RegWindow: win_reg <= cfg_data[6:0];
                RegMin:    min_reg <= cfg_data;
                RegMax:    max_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Prefix sum and point stores: one write port; two read ports on the sums, one on the points
    logic [SumYW-1:0]  mem_y  [MaxRows];
    logic [SumYW-1:0]  mem_z  [MaxRows];
    logic [SumYzW-1:0] mem_yz [MaxRows];
    logic [SumYyW-1:0] mem_yy [MaxRows];
    logic [PtW-1:0]    mem_pt [MaxRows];
    logic              valid_reg [MaxRows];

    logic [CntW-1:0] cnt_reg;
    logic            wr_en;
    logic [RowW-1:0] wr_addr;
    logic signed [SumYW-1:0]  run_y_reg, run_z_reg;
    logic signed [SumYzW-1:0] run_yz_reg;
    logic signed [SumYyW-1:0] run_yy_reg;
    logic signed [SumYW-1:0]  add_y, add_z;
    logic signed [SumYzW-1:0] add_yz;
    logic signed [SumYyW-1:0] add_yy;
    logic signed [31:0]       p_yz, p_yy;
    logic                     row_in;

    assign wr_en   = cmd.load_row && (cnt_reg < CntW'(MaxRows));
    assign wr_addr = cnt_reg[RowW-1:0];
    assign row_in  = s_depth_ok && (cnt_reg != '0);
    assign p_yz    = s_point_y * s_point_z;
    assign p_yy    = s_point_y * s_point_y;
    assign add_y   = row_in ? run_y_reg + SumYW'(s_point_y) : run_y_reg;
    assign add_z   = row_in ? run_z_reg + SumYW'(s_point_z) : run_z_reg;
    assign add_yz  = row_in ? run_yz_reg + SumYzW'(p_yz) : run_yz_reg;
    assign add_yy  = row_in ? run_yy_reg + SumYyW'(p_yy) : run_yy_reg;

    // Running sums restart at each column
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.finish) begin
            run_y_reg  <= '0;
            run_z_reg  <= '0;
            run_yz_reg <= '0;
            run_yy_reg <= '0;
        end else if (wr_en) begin
            run_y_reg  <= add_y;
            run_z_reg  <= add_z;
            run_yz_reg <= add_yz;
            run_yy_reg <= add_yy;
        end
    end

    // Store row entries
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_y[wr_addr]  <= add_y;
            mem_z[wr_addr]  <= add_z;
            mem_yz[wr_addr] <= add_yz;
            mem_yy[wr_addr] <= add_yy;
            mem_pt[wr_addr] <= {s_point_x, s_point_y, s_point_z};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) valid_reg[wr_addr] <= row_in;
    end

    // Row count
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.finish) cnt_reg <= '0;
        else if (wr_en)             cnt_reg <= cnt_reg + 1'b1;
    end

    // Scan index and window addresses
    logic [CntW:0]   scan_reg;
    logic [CntW:0]   half;
    logic [CntW:0]   hi_a, lo_a;
    logic [RowW-1:0] rd_row, rd_hi, rd_lo;

    assign half = (CntW+1)'(win_reg[6:1]);
    assign hi_a = scan_reg + half;
    assign lo_a = scan_reg - half;
    assign rd_row = scan_reg[RowW-1:0];
    assign rd_hi  = hi_a[RowW-1:0];
    assign rd_lo  = lo_a[RowW-1:0];
    assign stat.scan_empty =
        ({1'b0, scan_reg} + {1'b0, (CntW+1)'(win_reg)}) >= (CntW+2)'(cnt_reg);

    always_ff @(posedge aclk) begin
        if (cmd.scan_start)  scan_reg <= (CntW+1)'(win_reg);
        else if (cmd.decide) scan_reg <= scan_reg + 1'b1;
    end

    // Registered store reads, held until the next scan row is read
    logic [SumYW-1:0]  hy_reg, ly_reg, hz_reg, lz_reg;
    logic [SumYzW-1:0] hyz_reg, lyz_reg;
    logic [SumYyW-1:0] hyy_reg, lyy_reg;
    logic [PtW-1:0]    pt_reg;
    logic              pv_reg;

    always_ff @(posedge aclk) begin
        if (cmd.scan_read) begin
            hy_reg  <= (rd_hi == '0) ? '0 : mem_y[rd_hi];
            ly_reg  <= (rd_lo == '0) ? '0 : mem_y[rd_lo];
            hz_reg  <= (rd_hi == '0) ? '0 : mem_z[rd_hi];
            lz_reg  <= (rd_lo == '0) ? '0 : mem_z[rd_lo];
            hyz_reg <= (rd_hi == '0) ? '0 : mem_yz[rd_hi];
            lyz_reg <= (rd_lo == '0) ? '0 : mem_yz[rd_lo];
            hyy_reg <= (rd_hi == '0) ? '0 : mem_yy[rd_hi];
            lyy_reg <= (rd_lo == '0) ? '0 : mem_yy[rd_lo];
            pt_reg  <= mem_pt[rd_row];
            pv_reg  <= valid_reg[rd_row];
        end
    end

    logic signed [15:0] pz;
    assign pz = pt_reg[15:0];
    assign stat.scan_skip = !pv_reg || (pz >= HighMm);

    // Window sums
    logic signed [SumYW-1:0]  sy, sz;
    logic signed [SumYzW-1:0] syz;
    logic signed [SumYyW-1:0] syy;
    assign sy  = hy_reg - ly_reg;
    assign sz  = hz_reg - lz_reg;
    assign syz = hyz_reg - lyz_reg;
    assign syy = hyy_reg - lyy_reg;

    // Stage one: Sy*Sz, Sy*Sy; stage two: W*Syz, W*Syy
    logic signed [SumYzW+8:0] wyz_reg;
    logic signed [SumYyW+8:0] wyy_reg;
    logic signed [51:0]       yz_reg, yy_reg;
    logic signed [7:0]        w_s;
    assign w_s = {1'b0, win_reg};

    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            yz_reg <= sy * sz;
            yy_reg <= sy * sy;
        end
        if (cmd.mul2) begin
            wyz_reg <= w_s * syz;
            wyy_reg <= w_s * syy;
        end
    end

    // num and den magnitudes
    logic [63:0] an_reg, ad_reg;
    logic signed [63:0] num, den;
    assign num = 64'(wyz_reg) - 64'(yz_reg);
    assign den = 64'(wyy_reg) - 64'(yy_reg);

    always_ff @(posedge aclk) begin
        if (cmd.sub) begin
            an_reg <= num[63] ? 64'(-num) : 64'(num);
            ad_reg <= den[63] ? 64'(-den) : 64'(den);
        end
    end

    // Threshold times |den| in two 32x16 partial products
    logic [47:0] plo_reg, phi_reg;
    logic [79:0] prod;
    logic        steep_reg;
    assign prod = {phi_reg, 32'd0} + 80'(plo_reg);

    always_ff @(posedge aclk) begin
        if (cmd.cmp_a) begin
            plo_reg <= ad_reg[31:0] * thr_reg;
            phi_reg <= ad_reg[63:32] * thr_reg;
        end
        if (cmd.cmp_b) begin
            if (ad_reg == '0) steep_reg <= an_reg != '0;
            else              steep_reg <= {8'd0, an_reg, 8'd0} > prod;
        end
    end

    // Best candidate
    logic               best_reg;
    logic [PtW-1:0]     bpt_reg;
    logic signed [15:0] by;
    logic               load_cand, scan_cand;
    assign by        = bpt_reg[31:16];
    assign load_cand = wr_en && row_in && (s_point_z > HighMm)
                       && (!best_reg || s_point_y < by);
    assign scan_cand = cmd.decide && !stat.scan_skip && steep_reg
                       && (!best_reg || $signed(pt_reg[31:16]) < by);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.finish) begin
            best_reg <= 1'b0;
            bpt_reg  <= '0;
        end else if (load_cand) begin
            best_reg <= 1'b1;
            bpt_reg  <= {s_point_x, s_point_y, s_point_z};
        end else if (scan_cand) begin
            best_reg <= 1'b1;
            bpt_reg  <= pt_reg;
        end
    end

    // Result register
    logic ok;
    assign ok = best_reg && (by < max_reg) && (by > min_reg)
                && ($signed(bpt_reg[15:0]) <= TopMm);

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_found  <= ok;
            m_near_x <= ok ? bpt_reg[47:32] : '0;
            m_near_y <= ok ? bpt_reg[31:16] : '0;
            m_near_z <= ok ? bpt_reg[15:0]  : '0;
        end
    end

endmodule

### design/depth_column_obstacle_scan_unit.sv
`timescale 1ns / 1ps
// Channel  | ports                                   | direction
// s_       | valid, ready, point x/y/z, depth_ok, last| row words in
// m_       | valid, ready, found, near_x/y/z         | one result word per column
// cfg_     | valid, ready, index, data               | register writes
// Load takes one row word per cycle into the prefix-sum memories.
// After the last row the scan walks rows W .. height-W-1. Each row is read;
// a slope-tested row then passes two multiply stages, subtract, split threshold
// product and compare before the decide step, while a skipped row goes straight
// to decide. A final empty check leads to the output state and result register.
// Reset clears control, counters and configuration; memories are not cleared.
// A stalled result word holds while the next column loads; that column's
// result waits in the output state until the held word is taken.

module depth_column_obstacle_scan_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_point_x,
    input  logic signed [15:0] s_point_y,
    input  logic signed [15:0] s_point_z,
    input  logic               s_depth_ok,
    input  logic               s_last_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found,
    output logic signed [15:0] m_near_x,
    output logic signed [15:0] m_near_y,
    output logic signed [15:0] m_near_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import dcos_pkg::*;

    dcos_cmd_t  cmd;
    dcos_stat_t stat;

    assign cfg_ready = 1'b1;

    dcos_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_last_row,
        .m_valid, .m_ready, .cmd, .stat
    );

    dcos_dp u_dp (
        .aclk, .aresetn, .s_point_x, .s_point_y, .s_point_z, .s_depth_ok,
        .cfg_valid, .cfg_index, .cfg_data,
        .m_found, .m_near_x, .m_near_y, .m_near_z, .cmd, .stat
    );

endmodule

### design/dcos_checker.sv
`timescale 1ns / 1ps

module dcos_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_last_row,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_found,
    input logic signed [15:0] m_near_y
);
    // Result valid, found and near_y hold while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_near_y))
        else $error("result word changed under stall");

    // Not found carries a zero near_y coordinate
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_near_y == 16'sd0)
        else $error("coordinate not zero without a find");

    // Stop taking rows once the last row of a column is in
    a_sep: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_row |=> !s_ready)
        else $error("row taken straight after the last row");

endmodule

bind depth_column_obstacle_scan_unit dcos_checker u_dcos_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .s_last_row, .m_valid, .m_ready, .m_found,
    .m_near_y
);

### dv/depth_column_obstacle_scan_unit_tb.sv
`timescale 1ns / 1ps

module depth_column_obstacle_scan_unit_tb;
    import dcos_pkg::*;

    typedef struct packed {
        logic               found;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } verdict_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_point_x = '0;
    logic signed [15:0] s_point_y = '0;
    logic signed [15:0] s_point_z = '0;
    logic               s_depth_ok = 1'b0;
    logic               s_last_row = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_found;
    logic signed [15:0] m_near_x;
    logic signed [15:0] m_near_y;
    logic signed [15:0] m_near_z;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    depth_column_obstacle_scan_unit dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Predictor copy of configuration and column state
    logic [15:0]        slope_lim;
    logic [6:0]         win;
    logic signed [15:0] lo_range;
    logic signed [15:0] hi_range;
    longint             acc_y [MaxRows];
    longint             acc_z [MaxRows];
    longint             acc_yz [MaxRows];
    longint             acc_yy [MaxRows];
    logic signed [15:0] pt [MaxRows][3];
    bit                 pt_ok [MaxRows];
    int                 rows_held;
    logic signed [15:0] near_pt [3];
    bit                 near_have;

    verdict_t verdicts_due[$];
    int       errors;
    int       columns_seen;
    int       found_seen;
    longint   cycles = 0;
    int       burst_left;

    function automatic void offer_near(logic signed [15:0] px, py, pz);
        if (!near_have || py < near_pt[1]) begin
            near_pt[0] = px;
            near_pt[1] = py;
            near_pt[2] = pz;
            near_have = 1'b1;
        end
    endfunction

    function automatic bit is_steep(int r, int w);
        longint sy, sz, syz, syy, num, den;
        longint unsigned an, ad;
        sy  = acc_y[r + w / 2] - acc_y[r - w / 2];
        sz  = acc_z[r + w / 2] - acc_z[r - w / 2];
        syz = acc_yz[r + w / 2] - acc_yz[r - w / 2];
        syy = acc_yy[r + w / 2] - acc_yy[r - w / 2];
        num = longint'(w) * syz - sy * sz;
        den = longint'(w) * syy - sy * sy;
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        if (ad == 0) return an != 0;
        return an * 256 > longint'(slope_lim) * ad;
    endfunction

    // Fold one row into the column; queue the verdict on the last row
    function automatic void predict_row(logic signed [15:0] px, py, pz, bit ok, bit last);
        int r;
        int w;
        verdict_t v;
        if (rows_held < MaxRows) begin
            r = rows_held;
            if (r == 0) begin
                acc_y[0] = 0; acc_z[0] = 0; acc_yz[0] = 0; acc_yy[0] = 0;
                pt_ok[0] = 1'b0;
            end else begin
                acc_y[r] = acc_y[r-1]; acc_z[r] = acc_z[r-1];
                acc_yz[r] = acc_yz[r-1]; acc_yy[r] = acc_yy[r-1];
                pt_ok[r] = ok;
                if (ok) begin
                    pt[r][0] = px; pt[r][1] = py; pt[r][2] = pz;
                    acc_y[r] += py;
                    acc_z[r] += pz;
                    acc_yz[r] += longint'(py) * longint'(pz);
                    acc_yy[r] += longint'(py) * longint'(py);
                    if (pz > HighMm) offer_near(px, py, pz);
                end
            end
            rows_held = r + 1;
        end
        if (!last) return;
        w = win;
        for (int k = w; k < rows_held - w; k++) begin
            if (pt_ok[k] && pt[k][2] < HighMm && is_steep(k, w))
                offer_near(pt[k][0], pt[k][1], pt[k][2]);
        end
        v.found = near_have && near_pt[1] < hi_range && near_pt[1] > lo_range
                  && near_pt[2] <= TopMm;
        v.x = v.found ? near_pt[0] : '0;
        v.y = v.found ? near_pt[1] : '0;
        v.z = v.found ? near_pt[2] : '0;
        verdicts_due = {verdicts_due, v};
        rows_held = 0;
        near_have = 1'b0;
        near_pt[0] = '0; near_pt[1] = '0; near_pt[2] = '0;
    endfunction

    // Send one row word, with bursty gaps
    task automatic send_row(logic signed [15:0] px, py, pz, bit ok, bit last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_point_x <= px; s_point_y <= py; s_point_z <= pz;
        s_depth_ok <= ok; s_last_row <= last;
        do @(posedge aclk); while (!(s_valid && s_ready));
        predict_row(px, py, pz, ok, last);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        case (idx)
            RegSlope:  slope_lim = val;
            RegWindow: win = val[6:0];
            RegMin:    lo_range = val;
            default:   hi_range = val;
        endcase
    endtask

    // Drop valid, wait for all verdicts, then let the scan settle
    task automatic drain();
        s_valid <= 1'b0;
        wait (verdicts_due.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_config(logic [15:0] th, logic [6:0] w, logic signed [15:0] lo, hi);
        drain();
        write_reg(RegSlope, th);
        write_reg(RegWindow, {9'd0, w});
        write_reg(RegMin, lo);
        write_reg(RegMax, hi);
        cfg_valid <= 1'b0;
    endtask

    // Floor rows with an optional ramp; shape covers slope and height cases
    task automatic send_column(int n, int ramp_at);
        logic signed [15:0] y, z;
        for (int i = 0; i < n; i++) begin
            y = 16'(300 + i * $urandom_range(5, 40));
            z = (ramp_at >= 0 && i >= ramp_at) ? 16'((i - ramp_at) * $urandom_range(5, 60))
                                               : 16'($urandom_range(0, 20) - 10);
            if ($urandom_range(0, 15) == 0) z = 16'($urandom_range(150, 1900));
            send_row(16'($urandom), y, z, $urandom_range(0, 7) != 0, i == n - 1);
        end
    endtask

    task automatic test_directed();
        set_config(16'd256, 7'd10, 16'sd0, 16'sd3000);
        send_row(16'sd1, 16'sd5, 16'sd500, 1'b1, 1'b1);      // single-row column
        send_row(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0);
        send_row(16'sh7fff, 16'sd1000, 16'sd200, 1'b1, 1'b0);  // height exactly 200
        send_row(-16'sh8000, 16'sd900, 16'sd201, 1'b1, 1'b0);
        send_row(16'sd3, 16'sd900, 16'sd1700, 1'b1, 1'b0);     // tie keeps earlier
        send_row(16'sd4, 16'sd800, 16'sd1701, 1'b0, 1'b1);     // skipped row
        send_row(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0);
        send_row(16'sd9, -16'sh8000, -16'sh8000, 1'b1, 1'b0);
        send_row(-16'sd9, 16'sh7fff, 16'sh7fff, 1'b1, 1'b0);
        send_row(16'sd2, 16'sd100, 16'sd1800, 1'b1, 1'b1);     // too tall
        set_config(16'd0, 7'd2, -16'sh8000, 16'sh7fff);
        send_column(12, 6);
        set_config(16'hffff, 7'd0, 16'sd0, 16'sd3000);
        send_column(8, 3);
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 580) begin
            if ($urandom_range(0, 5) == 0)
                set_config(16'($urandom_range(0, 2000)), 7'($urandom_range(0, 12)),
                           16'($urandom_range(0, 400) - 200),
                           16'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1000, 9000)));
            if ($urandom_range(0, 9) == 0) begin
                // raw noise column with full-range fields
                for (int i = 0; i < 6; i++)
                    send_row(16'($urandom), 16'($urandom), 16'($urandom),
                             $urandom_range(0, 1), i == 5);
                sent += 6;
            end else begin
                int n;
                n = $urandom_range(2, 60);
                send_column(n, $urandom_range(0, 1) ? int'($urandom_range(1, n)) : -1);
                sent += n;
            end
        end
    endtask

    task automatic test_overflow();
        set_config(16'd256, 7'd64, 16'sd0, 16'sh7fff);
        send_column(MaxRows + 5, 300);
        set_config(16'd256, 7'd4, 16'sd0, 16'sh7fff);
        send_column(MaxRows + 1, 200);
    endtask

    // Result checker and receiver stall pattern
    always @(posedge aclk) begin
        verdict_t v;
        cycles <= cycles + 1;
        if (aresetn) m_ready <= (cycles % 11) < 7 || cycles[12];
        if (aresetn && m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                v = verdicts_due.pop_front();
                columns_seen++;
                if (v.found) found_seen++;
                if (m_found !== v.found) begin
                    $error("found exp %0d got %0d", v.found, m_found); errors++;
                end
                if (m_near_x !== v.x) begin
                    $error("near_x exp %0d got %0d", v.x, m_near_x); errors++;
                end
                if (m_near_y !== v.y) begin
                    $error("near_y exp %0d got %0d", v.y, m_near_y); errors++;
                end
                if (m_near_z !== v.z) begin
                    $error("near_z exp %0d got %0d", v.z, m_near_z); errors++;
                end
            end
        end
        if (cycles > 400000) begin
            $display("timeout after %0d cycles", cycles);
            $display("** depth_column_obstacle_scan_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        errors = 0; columns_seen = 0; found_seen = 0; burst_left = 0;
        slope_lim = 16'd256; win = 7'd10; lo_range = 16'sd0; hi_range = 16'sd3000;
        rows_held = 0; near_have = 1'b0;
        near_pt[0] = '0; near_pt[1] = '0; near_pt[2] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_overflow();
        drain();
        if (verdicts_due.size() != 0) errors++;
        $display("Checked %0d column results, %0d with an obstacle reported,", columns_seen,
                 found_seen);
        $display("over directed, random, config sweep and overflow columns.");
        if (errors == 0)
            $display("** depth_column_obstacle_scan_unit: PASSED **");
        else
            $display("** depth_column_obstacle_scan_unit: FAILED **");
        $finish;
    end

endmodule
